// File: rtl/hdlc_nrzi_stuffing_fcs_tx_unit_macros.svh
// ----------------------------------------------------------------------------
// HDLC transmitter assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef HDLC_NRZI_STUFFING_FCS_TX_UNIT_MACROS_SVH
`define HDLC_NRZI_STUFFING_FCS_TX_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define HTX_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hdlc tx check failed");
`define HTX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hdlc tx check failed");
`else
`define HTX_ASSERT_IMPL(lbl, ante, cons)
`define HTX_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/hdlctx_pkg.sv
// ----------------------------------------------------------------------------
// HDLC transmitter package
// Word types, request codes and CRC constants shared by the transmitter.
// ----------------------------------------------------------------------------
package hdlctx_pkg;

  localparam logic [1:0] REQ_DATA    = 2'd0;
  localparam logic [1:0] REQ_FLAG    = 2'd1;
  localparam logic [1:0] REQ_FCS     = 2'd2;
  localparam logic [1:0] REQ_RESTART = 2'd3;

  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] STUFF_RUN = 8'd5;

  localparam int MAX_RESULTS = 20;
  localparam int ECNT_W      = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic tone_mark;
    logic stuffed;
    logic last;
  } out_word_t;

  typedef struct packed {
    logic              busy;
    logic              pend;
    logic [ECNT_W-1:0] ecnt;
  } ser_stat_t;

endpackage

// File: rtl/hdlc_nrzi_stuffing_fcs_tx_unit.sv
// ----------------------------------------------------------------------------
// HDLC NRZI transmitter with bit stuffing and FCS
// Turns byte requests into NRZI line bits, one bit word per unstalled cycle.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_stall/req): data byte (stuffed), flag byte
// (unstuffed), FCS append (two complemented CRC bytes, stuffed) or FCS
// restart. Bytes go out LSB first.
// Line channel (bit_valid/bit_stall/line): one word per line bit with the
// tone level, a stuff-bit mark and a last mark on the request's final bit.
// A request is captured in the serializer's holding registers and its first
// line bit is then registered in the output register. One line bit per cycle
// goes out while the line side does not stall; a data byte yields 8 to 10
// bits, a flag 8, an FCS append 16 to 20 and a restart none. The next request
// is taken in the cycle its predecessor's final bit is issued.
// Reset: CRC all ones, line level space, run count zero, both channels idle.
// When the line side stalls, the held bit stays put and the serializer
// pauses; the request side stalls once its one-deep holding slot is full.
// ----------------------------------------------------------------------------
module hdlc_nrzi_stuffing_fcs_tx_unit
  import hdlctx_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  in_word_t  req,
  output logic      bit_valid,
  input  logic      bit_stall,
  output out_word_t line
);

`include "hdlc_nrzi_stuffing_fcs_tx_unit_macros.svh"

  logic      adv;
  logic      emit_valid;
  out_word_t emit_word;
  ser_stat_t stat;

  hdlctx_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .adv        (adv),
    .emit_valid (emit_valid),
    .emit_word  (emit_word),
    .stat       (stat)
  );

  hdlctx_oreg u_oreg (
    .clk        (clk),
    .rst        (rst),
    .emit_valid (emit_valid),
    .emit_word  (emit_word),
    .adv        (adv),
    .bit_valid  (bit_valid),
    .bit_stall  (bit_stall),
    .line       (line)
  );

  `HTX_ASSERT_IMPL(a_pend_busy, stat.pend, stat.busy)
  `HTX_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, stat.busy)
  `HTX_ASSERT_IMPL(a_ecnt_cap, 1'b1, stat.ecnt <= ECNT_W'(MAX_RESULTS))

endmodule

// File: rtl/hdlctx_ser.sv
// ----------------------------------------------------------------------------
// HDLC transmitter serializer
// Steps one held request a line bit per unstalled cycle: CRC, NRZI, stuffing.
// ----------------------------------------------------------------------------
module hdlctx_ser
  import hdlctx_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  in_word_t  req,
  input  logic      adv,
  output logic      emit_valid,
  output out_word_t emit_word,
  output ser_stat_t stat
);

  logic              busy;
  logic [1:0]        kind;
  logic [15:0]       sh;
  logic [4:0]        idx;
  logic              pend;
  logic [ECNT_W-1:0] ecnt;
  logic [15:0]       crc;
  logic              level;
  logic [7:0]        run;

  logic [15:0]       sh_next;
  logic [4:0]        idx_next;
  logic              pend_next;
  logic [ECNT_W-1:0] ecnt_next;
  logic [15:0]       crc_next;
  logic              level_next;
  logic [7:0]        run_next;

  logic [4:0]  nbits;
  logic [15:0] src;
  logic        sbit;
  logic        fb;
  logic [15:0] crc_step;
  logic [4:0]  idx_inc;
  logic [7:0]  run_inc;
  logic        stuff_now;
  logic        emit;
  logic        fin;
  logic        step;
  logic        room;
  logic        accept;

  assign step     = busy && adv;
  assign nbits    = (kind == REQ_FCS) ? 5'd16 : 5'd8;
  assign src      = (kind == REQ_FCS && idx == 5'd0) ? ~crc : sh;
  assign sbit     = src[0];
  assign fb       = crc[0] ^ sbit;
  assign crc_step = (crc >> 1) ^ (fb ? CRC_POLY : 16'h0000);
  assign idx_inc  = idx + 5'd1;
  assign run_inc  = run + 8'd1;
  assign stuff_now = (kind != REQ_FLAG) && (run_inc == STUFF_RUN);
  assign room     = ecnt < ECNT_W'(MAX_RESULTS);

  always_comb begin
    sh_next    = sh;
    idx_next   = idx;
    pend_next  = pend;
    crc_next   = crc;
    level_next = level;
    run_next   = run;
    emit       = 1'b0;
    fin        = 1'b0;
    emit_word  = '0;
    if (kind == REQ_RESTART) begin
      crc_next = CRC_INIT;
      fin      = 1'b1;
    end else if (pend) begin
      level_next = ~level;
      run_next   = 8'd0;
      pend_next  = 1'b0;
      emit       = 1'b1;
      fin        = (idx == nbits);
      emit_word.tone_mark = ~level;
      emit_word.stuffed   = 1'b1;
    end else begin
      crc_next = crc_step;
      sh_next  = src >> 1;
      idx_next = idx_inc;
      emit     = 1'b1;
      if (sbit) begin
        emit_word.tone_mark = level;
        if (stuff_now) begin
          pend_next = 1'b1;
          run_next  = 8'd0;
        end else begin
          run_next = run_inc;
        end
        fin = (idx_inc == nbits) && !stuff_now;
      end else begin
        level_next = ~level;
        run_next   = 8'd0;
        emit_word.tone_mark = ~level;
        fin = (idx_inc == nbits);
      end
    end
    emit_word.last = fin || (ecnt == ECNT_W'(MAX_RESULTS - 1));
  end

  assign emit_valid = step && emit && room;
  assign ecnt_next  = ecnt + ((emit && room) ? ECNT_W'(1) : ECNT_W'(0));
  assign req_stall  = busy && !(step && fin);
  assign accept     = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      pend  <= 1'b0;
      crc   <= CRC_INIT;
      level <= 1'b0;
      run   <= 8'd0;
      ecnt  <= '0;
    end else begin
      if (step) begin
        crc   <= crc_next;
        level <= level_next;
        run   <= run_next;
      end
      if (accept) begin
        busy <= 1'b1;
        pend <= 1'b0;
        ecnt <= '0;
      end else if (step) begin
        pend <= pend_next;
        ecnt <= ecnt_next;
        if (fin) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind <= req.req_type;
      sh   <= {8'h00, req.data_byte};
      idx  <= 5'd0;
    end else if (step) begin
      sh  <= sh_next;
      idx <= idx_next;
    end
  end

  assign stat.busy = busy;
  assign stat.pend = pend;
  assign stat.ecnt = ecnt;

endmodule

// File: rtl/hdlctx_oreg.sv
// ----------------------------------------------------------------------------
// HDLC transmitter output register
// One-entry result register toward the line side.
// ----------------------------------------------------------------------------
module hdlctx_oreg
  import hdlctx_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      emit_valid,
  input  out_word_t emit_word,
  output logic      adv,
  output logic      bit_valid,
  input  logic      bit_stall,
  output out_word_t line
);

  assign adv = !bit_valid || !bit_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_valid <= 1'b0;
    end else if (adv) begin
      bit_valid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit_valid) begin
      line <= emit_word;
    end
  end

endmodule
